// ----- rtl/core/one_shot_timer_table_assert.svh -----
// Assertion macros for the one-shot timer table checker.
`ifndef ONE_SHOT_TIMER_TABLE_ASSERT_SVH
`define ONE_SHOT_TIMER_TABLE_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define OTMR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OTMR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/otmr_pkg.sv -----
package otmr_pkg;

   localparam int KIND_W    = 3;
   localparam int ID_W      = 4;
   localparam int PERIOD_W  = 16;
   localparam int TSTATE_W  = 2;
   localparam int MASK_W    = 16;

   localparam int DEF_NUM_TIMERS = 16;
   localparam int DEF_COUNT_BITS = 16;

   localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CONTROL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESET   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd5;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   localparam logic [TSTATE_W-1:0] TSTATE_STOPPED = 2'd0;
   localparam logic [TSTATE_W-1:0] TSTATE_RUNNING = 2'd1;
   localparam logic [TSTATE_W-1:0] TSTATE_INVALID = 2'd2;

   typedef struct packed {
      logic load;
      logic exec;
      logic walk;
      logic publish;
   } otmr_cmd_type;

   typedef struct packed {
      logic req_is_tick;
      logic walk_done;
   } otmr_stat_type;

endpackage

// ----- rtl/core/otmr_req_if.sv -----
interface otmr_req_if;
   logic                          valid;
   logic                          ready;
   logic [otmr_pkg::KIND_W-1:0]   kind;
   logic [otmr_pkg::ID_W-1:0]     timer_id;
   logic [otmr_pkg::PERIOD_W-1:0] period;
   logic                          new_state;
   logic                          has_handler;

   modport source (output valid, kind, timer_id, period, new_state, has_handler,
                   input ready);
   modport sink   (input valid, kind, timer_id, period, new_state, has_handler,
                   output ready);
endinterface

// ----- rtl/core/otmr_rsp_if.sv -----
interface otmr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic [otmr_pkg::TSTATE_W-1:0] timer_state;
   logic [otmr_pkg::MASK_W-1:0]   expired_mask;

   modport source (output valid, status, timer_state, expired_mask, input ready);
   modport sink   (input valid, status, timer_state, expired_mask, output ready);
endinterface

// ----- rtl/core/otmr_ctrl.sv -----
module otmr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  otmr_pkg::otmr_stat_type stat,
   output otmr_pkg::otmr_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMD,
      ST_TICK,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign accept    = req_valid && req_ready_ff;
   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load     = 1'b1;
               req_ready_in = 1'b0;
               state_in     = stat.req_is_tick ? ST_TICK : ST_CMD;
            end else begin
               req_ready_in = 1'b1;
            end
         end
         ST_CMD: begin
            cmd.exec = 1'b1;
            state_in = ST_DONE;
         end
         ST_TICK: begin
            cmd.walk = 1'b1;
            if (stat.walk_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               req_ready_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/otmr_dp.sv -----
module otmr_dp #(
   parameter int NUM_TIMERS = otmr_pkg::DEF_NUM_TIMERS,
   parameter int COUNT_BITS = otmr_pkg::DEF_COUNT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  otmr_pkg::otmr_cmd_type        cmd,
   output otmr_pkg::otmr_stat_type       stat,
   input  logic [otmr_pkg::KIND_W-1:0]   req_kind,
   input  logic [otmr_pkg::ID_W-1:0]     req_timer_id,
   input  logic [otmr_pkg::PERIOD_W-1:0] req_period,
   input  logic                          req_new_state,
   input  logic                          req_has_handler,
   output logic                          rsp_status,
   output logic [otmr_pkg::TSTATE_W-1:0] rsp_timer_state,
   output logic [otmr_pkg::MASK_W-1:0]   rsp_expired_mask
);

   localparam int IDX_BITS = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int WALK_BITS = IDX_BITS + 1;
   localparam int CMP_W = (COUNT_BITS > otmr_pkg::PERIOD_W) ? COUNT_BITS
                                                            : otmr_pkg::PERIOD_W;
   localparam logic [IDX_BITS-1:0]  LAST_IDX = IDX_BITS'(NUM_TIMERS - 1);
   localparam logic [WALK_BITS-1:0] WALK_END = WALK_BITS'(NUM_TIMERS);

   // latched transaction
   logic [otmr_pkg::KIND_W-1:0]   kind_ff;
   logic [IDX_BITS-1:0]           idx_ff;
   logic                          inside_ff;
   logic [otmr_pkg::PERIOD_W-1:0] period_ff;
   logic                          ns_ff;
   logic                          hh_ff;

   logic [NUM_TIMERS-1:0] present_ff;
   logic [NUM_TIMERS-1:0] running_ff;

   logic [COUNT_BITS-1:0]         count_mem  [NUM_TIMERS];
   logic [otmr_pkg::PERIOD_W-1:0] period_mem [NUM_TIMERS];

   logic [COUNT_BITS-1:0]         rd_count_ff;
   logic [otmr_pkg::PERIOD_W-1:0] rd_period_ff;
   logic [WALK_BITS-1:0]          walk_idx_ff;
   logic [IDX_BITS-1:0]           proc_idx_ff;
   logic                          pipe_vld_ff;

   logic                          res_status_ff;
   logic [otmr_pkg::TSTATE_W-1:0] res_tstate_ff;
   logic [otmr_pkg::MASK_W-1:0]   res_mask_ff;

   logic                          out_status_ff;
   logic [otmr_pkg::TSTATE_W-1:0] out_tstate_ff;
   logic [otmr_pkg::MASK_W-1:0]   out_mask_ff;

   logic                  here;
   logic                  rd_en;
   logic                  active;
   logic                  expire;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic                  cnt_we;
   logic                  per_we;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [COUNT_BITS-1:0] cnt_wd;
   logic                  is_create;
   logic                  is_clear;

   assign stat.req_is_tick = (req_kind == otmr_pkg::KIND_TICK);
   assign stat.walk_done   = pipe_vld_ff && (proc_idx_ff == LAST_IDX);

   assign here    = inside_ff && present_ff[idx_ff];
   assign rd_en   = cmd.walk && (walk_idx_ff < WALK_END);
   assign active  = present_ff[proc_idx_ff] && running_ff[proc_idx_ff];
   assign cnt_inc = (&rd_count_ff) ? rd_count_ff : rd_count_ff + COUNT_BITS'(1);
   assign expire  = cmd.walk && pipe_vld_ff && active &&
                    (CMP_W'(cnt_inc) >= CMP_W'(rd_period_ff));

   assign is_create = (kind_ff == otmr_pkg::KIND_CREATE) && inside_ff;
   assign is_clear  = ((kind_ff == otmr_pkg::KIND_DELETE) ||
                       (kind_ff == otmr_pkg::KIND_RESET)) && here;
   assign per_we    = cmd.exec && is_create;
   assign cnt_we    = (cmd.exec && (is_create || is_clear)) ||
                      (cmd.walk && pipe_vld_ff && active);
   assign wr_addr   = cmd.walk ? proc_idx_ff : idx_ff;
   assign cnt_wd    = cmd.walk ? cnt_inc : '0;

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[wr_addr] <= cnt_wd;
      end
      if (per_we) begin
         period_mem[wr_addr] <= period_ff;
      end
      if (rd_en) begin
         rd_count_ff  <= count_mem[walk_idx_ff[IDX_BITS-1:0]];
         rd_period_ff <= period_mem[walk_idx_ff[IDX_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         idx_ff    <= IDX_BITS'(req_timer_id);
         inside_ff <= (32'(req_timer_id) < NUM_TIMERS);
         period_ff <= req_period;
         ns_ff     <= req_new_state;
         hh_ff     <= req_has_handler;
      end
      if (rd_en) begin
         proc_idx_ff <= walk_idx_ff[IDX_BITS-1:0];
      end
      if (cmd.publish) begin
         out_status_ff <= res_status_ff;
         out_tstate_ff <= res_tstate_ff;
         out_mask_ff   <= res_mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= '0;
         running_ff    <= '0;
         walk_idx_ff   <= '0;
         pipe_vld_ff   <= 1'b0;
         res_status_ff <= otmr_pkg::STATUS_OK;
         res_tstate_ff <= otmr_pkg::TSTATE_STOPPED;
         res_mask_ff   <= '0;
      end else begin
         if (cmd.load) begin
            walk_idx_ff   <= '0;
            pipe_vld_ff   <= 1'b0;
            res_status_ff <= otmr_pkg::STATUS_OK;
            res_tstate_ff <= otmr_pkg::TSTATE_STOPPED;
            res_mask_ff   <= '0;
         end
         if (cmd.walk) begin
            pipe_vld_ff <= rd_en;
            if (rd_en) begin
               walk_idx_ff <= walk_idx_ff + WALK_BITS'(1);
            end
            if (expire) begin
               running_ff[proc_idx_ff] <= 1'b0;
               res_mask_ff <= res_mask_ff | (otmr_pkg::MASK_W'(1) << proc_idx_ff);
            end
         end
         if (cmd.exec) begin
            case (kind_ff)
               otmr_pkg::KIND_CREATE: begin
                  if (inside_ff) begin
                     running_ff[idx_ff] <= ns_ff;
                     present_ff[idx_ff] <= hh_ff;
                  end
               end
               otmr_pkg::KIND_CONTROL: begin
                  if (here) begin
                     running_ff[idx_ff] <= ns_ff;
                  end else begin
                     res_status_ff <= otmr_pkg::STATUS_FAIL;
                  end
               end
               otmr_pkg::KIND_DELETE: begin
                  if (here) begin
                     running_ff[idx_ff] <= 1'b0;
                     present_ff[idx_ff] <= 1'b0;
                  end else begin
                     res_status_ff <= otmr_pkg::STATUS_FAIL;
                  end
               end
               otmr_pkg::KIND_RESET: begin
                  if (here) begin
                     running_ff[idx_ff] <= ns_ff;
                  end else begin
                     res_status_ff <= otmr_pkg::STATUS_FAIL;
                  end
               end
               otmr_pkg::KIND_QUERY: begin
                  if (here) begin
                     res_tstate_ff <= running_ff[idx_ff] ? otmr_pkg::TSTATE_RUNNING
                                                         : otmr_pkg::TSTATE_STOPPED;
                  end else begin
                     res_status_ff <= otmr_pkg::STATUS_FAIL;
                     res_tstate_ff <= otmr_pkg::TSTATE_INVALID;
                  end
               end
               default: begin
                  res_status_ff <= otmr_pkg::STATUS_FAIL;
               end
            endcase
         end
      end
   end

   assign rsp_status       = out_status_ff;
   assign rsp_timer_state  = out_tstate_ff;
   assign rsp_expired_mask = out_mask_ff;

endmodule

// ----- rtl/core/one_shot_timer_table.sv -----
// channel   dir  handshake      payload
// req_ch    in   valid/ready    kind, timer_id, period, new_state, has_handler
// rsp_ch    out  valid/ready    status, timer_state, expired_mask
//
// Commands go from accept through the CMD and DONE states to rsp valid; a tick
// walks the count/period memory in the TICK state, one timer per cycle, before DONE.
// One transaction in flight; the next is accepted while a response waits.
// Synchronous reset clears flags; count/period memory is written by create
// before any read that matters, so it needs no clearing pass.
module one_shot_timer_table #(
   parameter int NUM_TIMERS = otmr_pkg::DEF_NUM_TIMERS,
   parameter int COUNT_BITS = otmr_pkg::DEF_COUNT_BITS
) (
   input logic         clock,
   input logic         reset,
   otmr_req_if.sink    req_ch,
   otmr_rsp_if.source  rsp_ch
);

   otmr_pkg::otmr_cmd_type  cmd;
   otmr_pkg::otmr_stat_type stat;

   otmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   otmr_dp #(
      .NUM_TIMERS (NUM_TIMERS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_ch.kind),
      .req_timer_id     (req_ch.timer_id),
      .req_period       (req_ch.period),
      .req_new_state    (req_ch.new_state),
      .req_has_handler  (req_ch.has_handler),
      .rsp_status       (rsp_ch.status),
      .rsp_timer_state  (rsp_ch.timer_state),
      .rsp_expired_mask (rsp_ch.expired_mask)
   );

endmodule

// ----- rtl/core/otmr_checker.sv -----
`include "one_shot_timer_table_assert.svh"

module otmr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_status,
   input logic [otmr_pkg::TSTATE_W-1:0] rsp_timer_state,
   input logic [otmr_pkg::MASK_W-1:0]   rsp_expired_mask
);

   `OTMR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")
   `OTMR_ASSERT_NEXT(a_one_inflight, req_valid && req_ready, !req_ready, "ready after accept")
   `OTMR_ASSERT_SAME(a_invalid_fails, rsp_valid && (rsp_timer_state == otmr_pkg::TSTATE_INVALID), rsp_status == otmr_pkg::STATUS_FAIL, "invalid state with ok status")
   `OTMR_ASSERT_SAME(a_mask_is_tick, rsp_valid && (rsp_expired_mask != '0), (rsp_status == otmr_pkg::STATUS_OK) && (rsp_timer_state == otmr_pkg::TSTATE_STOPPED), "mask on non-tick response")

endmodule

bind one_shot_timer_table otmr_checker u_otmr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_timer_state  (rsp_ch.timer_state),
   .rsp_expired_mask (rsp_ch.expired_mask)
);
